### hdl/midi_channel_message_parser_defines.svh
// Assertion macros for the checker of the MIDI parser.
// Each expects clk and rst_n in scope.
`ifndef MIDI_CHANNEL_MESSAGE_PARSER_DEFINES_SVH
`define MIDI_CHANNEL_MESSAGE_PARSER_DEFINES_SVH

// Same-cycle implication, off while reset is held.
`define MCMP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is held.
`define MCMP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/mcmp_pkg.sv
package mcmp_pkg;

  // Command nibbles of the channel messages that are parsed
  localparam logic [3:0] CMD_NOTE_OFF = 4'd8;
  localparam logic [3:0] CMD_NOTE_ON  = 4'd9;
  localparam logic [3:0] CMD_PRESSURE = 4'd10;
  localparam logic [3:0] CMD_CONTROL  = 4'd11;
  localparam logic [3:0] CMD_PROGRAM  = 4'd12;

  // Message kind codes on the result channel
  localparam logic [2:0] KIND_NOTE_OFF = 3'd0;
  localparam logic [2:0] KIND_NOTE_ON  = 3'd1;
  localparam logic [2:0] KIND_PRESSURE = 3'd2;
  localparam logic [2:0] KIND_CONTROL  = 3'd3;
  localparam logic [2:0] KIND_PROGRAM  = 3'd4;

endpackage

### hdl/midi_channel_message_parser.sv
// MIDI channel message parser with running status. Feed one received byte
// per item on the in_ channel; a byte with bit 7 set is a status byte and
// replaces the stored command and channel (this includes system and
// real-time bytes such as timing clock and active sensing, after which data
// bytes are dropped until the next channel status). Note off, note on, poly
// pressure and control change produce one result after two data bytes;
// program change produces one result per data byte, with the program number
// reported plus one and second_value zero. midi_channel is 1..16. Data bytes
// under any other command, or before any status byte, produce nothing.
// The parser state and the result register both update at the accepting
// edge, and a result appears on out_ in the cycle after the data byte that
// completes it. A new item is taken in every cycle unless a result sits in
// the output register while out_stall is high.
module midi_channel_message_parser
  import mcmp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  // input item channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  // result item channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_msg_kind,
  output logic [4:0] out_midi_channel,
  output logic [7:0] out_first_value,
  output logic [6:0] out_second_value
);

  // Parser state
  logic [3:0] status_r,  status_nxt;
  logic [3:0] chan_r,    chan_nxt;
  logic [6:0] first_r,   first_nxt;
  logic       held_r,    held_nxt;   // first data byte of a pair is held

  // Result register
  logic       res_valid_r, res_valid_nxt;
  logic [2:0] res_kind_r,  res_kind_nxt;
  logic [4:0] res_chan_r,  res_chan_nxt;
  logic [7:0] res_first_r, res_first_nxt;
  logic [6:0] res_second_r, res_second_nxt;

  logic accept;
  logic is_status;
  logic two_byte_cmd;
  logic program_cmd;
  logic emit;

  // Hold the input only while a result waits and the sink stalls it
  assign in_stall  = res_valid_r & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign is_status = in_rx_byte[7];

  // Note off .. control change share the top bits 2'b10
  assign two_byte_cmd = (status_r >= CMD_NOTE_OFF) && (status_r <= CMD_CONTROL);
  assign program_cmd  = (status_r == CMD_PROGRAM);

  // A data byte completes a message on the second byte of a pair, or at once
  // under program change
  assign emit = accept & ~is_status & ((two_byte_cmd & held_r) | program_cmd);

  // Parser state update
  always_comb begin
    status_nxt = status_r;
    chan_nxt   = chan_r;
    first_nxt  = first_r;
    held_nxt   = held_r;
    if (accept) begin
      if (is_status) begin
        // Store command and channel, restart the data count
        status_nxt = in_rx_byte[7:4];
        chan_nxt   = in_rx_byte[3:0];
        held_nxt   = 1'b0;
      end else if (two_byte_cmd) begin
        if (!held_r) begin
          first_nxt = in_rx_byte[6:0];
          held_nxt  = 1'b1;
        end else begin
          held_nxt  = 1'b0;
        end
      end else if (program_cmd) begin
        first_nxt = in_rx_byte[6:0];
        held_nxt  = 1'b0;
      end else begin
        // Unknown command: drop the byte
        held_nxt = 1'b0;
      end
    end
  end

  // Result register update
  always_comb begin
    res_valid_nxt  = res_valid_r & out_stall;
    res_kind_nxt   = res_kind_r;
    res_chan_nxt   = res_chan_r;
    res_first_nxt  = res_first_r;
    res_second_nxt = res_second_r;
    if (emit) begin
      res_valid_nxt = 1'b1;
      res_chan_nxt  = {1'b0, chan_r} + 5'd1;
      if (program_cmd) begin
        res_kind_nxt   = KIND_PROGRAM;
        res_first_nxt  = {1'b0, in_rx_byte[6:0]} + 8'd1;
        res_second_nxt = 7'd0;
      end else begin
        // Kind is the command offset from note off
        res_kind_nxt   = {1'b0, status_r[1:0]};
        res_first_nxt  = {1'b0, first_r};
        res_second_nxt = in_rx_byte[6:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r    <= 4'd0;
      chan_r      <= 4'd0;
      held_r      <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      status_r    <= status_nxt;
      chan_r      <= chan_nxt;
      held_r      <= held_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    first_r      <= first_nxt;
    res_kind_r   <= res_kind_nxt;
    res_chan_r   <= res_chan_nxt;
    res_first_r  <= res_first_nxt;
    res_second_r <= res_second_nxt;
  end

  assign out_valid        = res_valid_r;
  assign out_msg_kind     = res_kind_r;
  assign out_midi_channel = res_chan_r;
  assign out_first_value  = res_first_r;
  assign out_second_value = res_second_r;

endmodule

### hdl/mcmp_checker.sv
`include "midi_channel_message_parser_defines.svh"

module mcmp_checker
  import mcmp_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_rx_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] out_msg_kind,
  input logic [4:0] out_midi_channel,
  input logic [7:0] out_first_value,
  input logic [6:0] out_second_value
);

  // A stalled result holds until taken
  `MCMP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_msg_kind) && $stable(out_first_value) && $stable(out_second_value) && $stable(out_midi_channel), "stalled result changed")

  // Channel numbers run 1..16
  `MCMP_ASSERT_NOW(a_chan_range, out_valid, out_midi_channel != 5'd0 && out_midi_channel <= 5'd16, "channel out of range")

  // Program change carries a nonzero program and no second value
  `MCMP_ASSERT_NOW(a_program_fields, out_valid && out_msg_kind == KIND_PROGRAM, out_second_value == 7'd0 && out_first_value != 8'd0, "bad program change fields")

  // A status byte never completes a message
  `MCMP_ASSERT_NEXT(a_status_no_result, in_valid && !in_stall && in_rx_byte[7], !out_valid, "result after status byte")

endmodule

bind midi_channel_message_parser mcmp_checker u_mcmp_checker (.*);

### verif/midi_channel_message_parser_tb.sv
package midi_parser_tb_pkg;
  import mcmp_pkg::*;

  typedef struct packed {
    logic [2:0] kind;
    logic [4:0] chan;
    logic [7:0] first_val;
    logic [6:0] second_val;
  } midi_msg_t;

  // Track the running status of the byte stream and hold the messages it
  // must produce, oldest first.
  class midi_msg_scoreboard;
    logic [3:0] cmd_nib;
    logic [3:0] chan_nib;
    logic [6:0] held_data;
    logic [1:0] held_count;
    midi_msg_t  expected_msgs[$];
    int unsigned err_count;

    function new();
      cmd_nib    = 4'd0;
      chan_nib   = 4'd0;
      held_data  = 7'd0;
      held_count = 2'd0;
      err_count  = 0;
    endfunction

    function int pending();
      return expected_msgs.size();
    endfunction

    function void note_rx_byte(logic [7:0] rx);
      midi_msg_t m;
      if (rx[7]) begin
        cmd_nib    = rx[7:4];
        chan_nib   = rx[3:0];
        held_count = 2'd0;
        return;
      end
      m.chan = {1'b0, chan_nib} + 5'd1;
      case (cmd_nib)
        CMD_NOTE_OFF, CMD_NOTE_ON, CMD_PRESSURE, CMD_CONTROL: begin
          if (held_count == 2'd0) begin
            held_data  = rx[6:0];
            held_count = 2'd1;
          end else begin
            held_count = 2'd0;
            case (cmd_nib)
              CMD_NOTE_OFF: m.kind = KIND_NOTE_OFF;
              CMD_NOTE_ON:  m.kind = KIND_NOTE_ON;
              CMD_PRESSURE: m.kind = KIND_PRESSURE;
              default:      m.kind = KIND_CONTROL;
            endcase
            m.first_val  = {1'b0, held_data};
            m.second_val = rx[6:0];
            expected_msgs.push_back(m);
          end
        end
        CMD_PROGRAM: begin
          held_data    = rx[6:0];
          held_count   = 2'd0;
          m.kind       = KIND_PROGRAM;
          m.first_val  = {1'b0, rx[6:0]} + 8'd1;
          m.second_val = 7'd0;
          expected_msgs.push_back(m);
        end
        default: held_count = 2'd0;
      endcase
    endfunction

    function void check_field(string what, int unsigned want, int unsigned got);
      if (want != got) begin
        err_count++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      end
    endfunction

    function void check_msg(logic [2:0] kind, logic [4:0] chan, logic [7:0] first_val,
                            logic [6:0] second_val);
      midi_msg_t m;
      if (expected_msgs.size() == 0) begin
        err_count++;
        $display("%0t: unexpected message, expected none, got kind %0d ch %0d %0d %0d",
                 $time, kind, chan, first_val, second_val);
        return;
      end
      m = expected_msgs.pop_front();
      check_field("msg_kind", m.kind, kind);
      check_field("midi_channel", m.chan, chan);
      check_field("first_value", m.first_val, first_val);
      check_field("second_value", m.second_val, second_val);
    endfunction
  endclass
endpackage

module midi_channel_message_parser_tb;
  import mcmp_pkg::*;
  import midi_parser_tb_pkg::*;

  // Command pool for well-formed channel messages.
  localparam logic [3:0] CHAN_CMDS [5] = '{CMD_NOTE_OFF, CMD_NOTE_ON, CMD_PRESSURE,
                                           CMD_CONTROL, CMD_PROGRAM};

  // Directed byte stream: data before any status, each command once, channels
  // 0 and 15, running status, program numbers 0 and 127, timing clock in the
  // middle of a message, active sensing before data, and an unknown command.
  localparam logic [7:0] DIRECTED_BYTES [26] = '{
    8'h7F,
    8'h90, 8'h00, 8'h7F, 8'h3C, 8'h40,
    8'h8F, 8'h7F, 8'h00,
    8'hA5, 8'h12, 8'h34,
    8'hB3, 8'h07, 8'h65,
    8'hC0, 8'h00, 8'h7F,
    8'h95, 8'h10, 8'hF8, 8'h20,
    8'hFE, 8'h30,
    8'hE4, 8'h55
  };

  localparam int PHASE_ITEMS = 240;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] out_msg_kind;
  logic [4:0] out_midi_channel;
  logic [7:0] out_first_value;
  logic [6:0] out_second_value;

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned items_sent = 0;

  midi_msg_scoreboard msg_board;

  midi_channel_message_parser u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_msg_kind     (out_msg_kind),
    .out_midi_channel (out_midi_channel),
    .out_first_value  (out_first_value),
    .out_second_value (out_second_value)
  );

  always #5 clk = ~clk;

  // Receiver side: stall at random, at the rate of the current phase.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Observe both handshakes at the edge. Everything read here holds its
  // pre-edge value, since all drivers update through nonblocking assignments.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        msg_board.check_msg(out_msg_kind, out_midi_channel, out_first_value,
                            out_second_value);
      end
      if (in_valid && !in_stall) begin
        msg_board.note_rx_byte(in_rx_byte);
      end
    end
  end

  // Offer one byte, idling first at the phase rate; hold it until taken.
  task automatic send_rx_byte(input logic [7:0] rx);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= rx;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Data bytes lean toward the extremes now and then.
  function automatic logic [7:0] rand_data();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'h7F;
    return 8'($urandom_range(127));
  endfunction

  // Mostly well-formed messages under running status; some broken by a
  // status byte mid-message, and some plain noise bytes.
  task automatic send_random_run();
    int unsigned pick;
    int unsigned msgs;
    logic [3:0]  cmd;
    pick = $urandom_range(99);
    cmd  = CHAN_CMDS[$urandom_range(4)];
    if (pick < 70) begin
      send_rx_byte({cmd, 4'($urandom_range(15))});
      msgs = $urandom_range(1, 4);
      repeat (msgs) begin
        send_rx_byte(rand_data());
        if (cmd != CMD_PROGRAM) send_rx_byte(rand_data());
      end
    end else if (pick < 88) begin
      send_rx_byte({cmd, 4'($urandom_range(15))});
      send_rx_byte(rand_data());
      send_rx_byte(8'($urandom_range(128, 255)));
      send_rx_byte(rand_data());
    end else begin
      send_rx_byte(8'($urandom_range(255)));
    end
  endtask

  initial begin
    int unsigned phase_end;
    msg_board = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, no idling.
    foreach (DIRECTED_BYTES[i]) send_rx_byte(DIRECTED_BYTES[i]);

    // Random part over four idling phases: none, sender idle, receiver
    // stalling, and light idling on both sides.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 66; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 66; end
        default: begin idle_pct = 7; stall_pct = 7; end
      endcase
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) send_random_run();
    end

    // Drain: drop valid, wait for every expected message, then keep clocking
    // so that the output register can show any stray result.
    in_valid <= 1'b0;
    while (msg_board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (msg_board.err_count == 0) begin
      $display("midi_channel_message_parser_tb: done, clean");
    end else begin
      $display("midi_channel_message_parser_tb: done, errors");
    end
    $finish;
  end

  // Hard stop far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("midi_channel_message_parser_tb: done, errors");
    $finish;
  end
endmodule

### sim.f
+incdir+hdl
hdl/mcmp_pkg.sv
hdl/midi_channel_message_parser.sv
hdl/mcmp_checker.sv
verif/midi_channel_message_parser_tb.sv
